>>> rtl/fcd_pkg.sv
// Package for the fan curve duty controller.
// Shared widths, register indexes, parameter defaults and the window control struct.
// No dependencies.
package fcd_pkg;

    localparam int DUTY_W             = 8;
    localparam int TEMP_W             = 8;
    localparam int CFG_W              = 64;
    localparam int CFG_IDX_W          = 3;
    localparam int DIV_W              = 16;

    localparam int DEF_HEATUP_DEPTH   = 4;
    localparam int DEF_COOLDOWN_DEPTH = 10;
    localparam int DEF_MAX_POINTS     = 8;
    localparam int DEF_HAS_GPU        = 1;
    localparam int DEF_SMOOTH_MIN     = 0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FULL_DUTY,
        REG_RAMP_UP,
        REG_RAMP_DOWN,
        REG_PTS_USED,
        REG_PTS_LOWER,
        REG_PTS_UPPER
    } cfg_reg_t;

    typedef struct packed {
        logic push;
        logic rot;
    } win_ctl_t;

endpackage

>>> rtl/fcd_win_cell.sv
// One cell of a duty window chain: holds one entry.
// Depends on fcd_pkg.
module fcd_win_cell
    import fcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [DUTY_W-1:0] d,
    output logic [DUTY_W-1:0] q
);

    logic [DUTY_W-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (adv)
        begin
            value_reg <= d;
        end
    end

    assign q = value_reg;

endmodule

>>> rtl/fcd_window.sv
// Duty window: a chain of cells that shifts toward the head.
// Push loads a new item at the tail; rotate moves the head to the tail.
// Depends on fcd_pkg and fcd_win_cell.
module fcd_window
    import fcd_pkg::*;
#(
    parameter int DEPTH = DEF_HEATUP_DEPTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  win_ctl_t          ctl,
    input  logic [DUTY_W-1:0] push_duty,
    output logic [DUTY_W-1:0] head
);

    logic [DUTY_W-1:0] cell_q [DEPTH];
    logic [DUTY_W-1:0] cell_d [DEPTH];
    logic              adv;

    assign adv = ctl.push | ctl.rot;

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            if (i == DEPTH - 1)
            begin : g_tail
                assign cell_d[i] = ctl.push ? push_duty : cell_q[0];
            end
            else
            begin : g_body
                assign cell_d[i] = cell_q[i+1];
            end

            fcd_win_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .adv   (adv),
                .d     (cell_d[i]),
                .q     (cell_q[i])
            );
        end
    endgenerate

    assign head = cell_q[0];

endmodule

>>> rtl/fcd_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Used for curve interpolation. Depends on fcd_pkg.
module fcd_divider
    import fcd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [7:0]        divisor,
    output logic [DIV_W-1:0]  quotient,
    output logic              done
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [7:0]       rem_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [7:0]       dsr_reg;

    logic [8:0]       trial;
    logic [8:0]       diff;
    logic             ge;

    assign trial = {rem_reg, quo_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsr_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? diff[7:0] : trial[7:0];
                quo_reg <= {quo_reg[DIV_W-2:0], ge};
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

>>> rtl/fan_curve_duty_controller.sv
// Fan curve duty controller: curve lookup, heat-up/cool-down windows, slew limit.
// Depends on fcd_pkg, fcd_window, fcd_divider.
//
//   channel | direction | handshake            | payload
//   in      | in        | in_valid / in_stall  | cpu_temp, gpu_temp, powered_on, force_max
//   out     | out       | out_valid / out_stall| fan_duty, target_duty
//   cfg     | in        | cfg_wr_en            | cfg_index, cfg_data
//
// One item at a time. Unpowered or forced items go straight to the finish state and the output register.
// Curve items scan up to n points (n = points used, capped at MAX_POINTS), multiply and divide
// when interpolated, then push and rotate the heat-up and cool-down windows, and finish.
// The output register holds a result while stalled; the next item is taken meanwhile.
// Reset clears windows, duty state and config to their defaults.
module fan_curve_duty_controller
    import fcd_pkg::*;
#(
    parameter int HEATUP_DEPTH    = DEF_HEATUP_DEPTH,
    parameter int COOLDOWN_DEPTH  = DEF_COOLDOWN_DEPTH,
    parameter int MAX_POINTS      = DEF_MAX_POINTS,
    parameter int HAS_GPU         = DEF_HAS_GPU,
    parameter int SMOOTH_MIN_DUTY = DEF_SMOOTH_MIN
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [TEMP_W-1:0] cpu_temp,
    input  logic signed [TEMP_W-1:0] gpu_temp,
    input  logic                     powered_on,
    input  logic                     force_max,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [DUTY_W-1:0]        fan_duty,
    output logic [DUTY_W-1:0]        target_duty,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]         cfg_data
);

    localparam int MAX_DEPTH = (HEATUP_DEPTH > COOLDOWN_DEPTH) ? HEATUP_DEPTH : COOLDOWN_DEPTH;
    localparam int ROT_W     = $clog2(MAX_DEPTH + 1);
    localparam logic [3:0]        MAXP = 4'(MAX_POINTS);
    localparam logic [DUTY_W-1:0] SMIN = DUTY_W'(SMOOTH_MIN_DUTY);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CURVE,
        ST_MUL,
        ST_DIV,
        ST_HU_PUSH,
        ST_HU_ROT,
        ST_CD_PUSH,
        ST_CD_ROT,
        ST_FINISH
    } state_t;

    state_t                     state_reg;

    logic [DUTY_W-1:0]          full_duty_reg;
    logic [DUTY_W-1:0]          ramp_up_reg;
    logic [DUTY_W-1:0]          ramp_down_reg;
    logic [3:0]                 pts_used_reg;
    logic [CFG_W-1:0]           pts_lower_reg;
    logic [CFG_W-1:0]           pts_upper_reg;

    logic signed [TEMP_W-1:0]   temp_reg;
    logic                       force_reg;
    logic [3:0]                 idx_reg;
    logic signed [TEMP_W-1:0]   pt_reg;
    logic [DUTY_W-1:0]          pd_reg;
    logic signed [17:0]         prod_reg;
    logic [7:0]                 dsr_reg;
    logic [DUTY_W-1:0]          duty_reg;
    logic [DUTY_W-1:0]          acc_reg;
    logic [ROT_W-1:0]           rot_cnt_reg;
    logic [DUTY_W-1:0]          smoothed_reg;
    logic [DUTY_W-1:0]          current_reg;
    logic                       out_valid_reg;
    logic [DUTY_W-1:0]          pwm_out_reg;
    logic [DUTY_W-1:0]          tgt_out_reg;

    // accept-side
    logic signed [TEMP_W-1:0]   temp_in;
    logic                       accept;

    // curve scan
    logic [3:0]                 n_eff;
    logic [2*CFG_W-1:0]         pts_all;
    logic [15:0]                cur_pt;
    logic signed [TEMP_W-1:0]   ct;
    logic [DUTY_W-1:0]          cd;
    logic signed [8:0]          dnum;
    logic signed [8:0]          ddiff;
    logic signed [8:0]          dden;
    logic signed [17:0]         prod_next;
    logic [17:0]                prod_mag;
    logic                       div_start;
    logic [DIV_W-1:0]           div_quo;
    logic                       div_done;
    logic [DUTY_W-1:0]          q8;
    logic [DUTY_W-1:0]          interp_duty;

    // windows
    win_ctl_t                   hu_ctl;
    win_ctl_t                   cd_ctl;
    logic [DUTY_W-1:0]          hu_head;
    logic [DUTY_W-1:0]          cd_head;
    logic [DUTY_W-1:0]          min_next;
    logic [DUTY_W-1:0]          max_next;

    // slew
    logic [8:0]                 up_sum;
    logic [DUTY_W-1:0]          up_cand;
    logic [DUTY_W-1:0]          dn_cand;
    logic [DUTY_W-1:0]          slew_next;
    logic                       changed;
    logic                       out_free;

    assign temp_in  = ((HAS_GPU != 0) && (gpu_temp > cpu_temp)) ? gpu_temp : cpu_temp;
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    assign n_eff    = (pts_used_reg > MAXP) ? MAXP : pts_used_reg;
    assign pts_all  = {pts_upper_reg, pts_lower_reg};
    assign cur_pt   = pts_all[idx_reg[2:0]*16 +: 16];
    assign ct       = signed'(cur_pt[7:0]);
    assign cd       = cur_pt[15:8];
    assign dnum     = 9'(temp_reg) - 9'(pt_reg);
    assign ddiff    = signed'({1'b0, cd}) - signed'({1'b0, pd_reg});
    assign dden     = 9'(ct) - 9'(pt_reg);
    assign prod_next = dnum * ddiff;

    assign prod_mag  = prod_reg[17] ? 18'(-prod_reg) : prod_reg;
    assign div_start = (state_reg == ST_MUL);
    assign q8        = div_quo[DUTY_W-1:0];
    assign interp_duty = pd_reg + (prod_reg[17] ? (~q8 + 8'd1) : q8);

    fcd_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_mag[DIV_W-1:0]),
        .divisor  (dsr_reg),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign hu_ctl.push = (state_reg == ST_HU_PUSH);
    assign hu_ctl.rot  = (state_reg == ST_HU_ROT);
    assign cd_ctl.push = (state_reg == ST_CD_PUSH);
    assign cd_ctl.rot  = (state_reg == ST_CD_ROT);

    fcd_window #(.DEPTH(HEATUP_DEPTH)) u_heatup (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (hu_ctl),
        .push_duty (duty_reg),
        .head      (hu_head)
    );

    fcd_window #(.DEPTH(COOLDOWN_DEPTH)) u_cooldown (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cd_ctl),
        .push_duty (duty_reg),
        .head      (cd_head)
    );

    assign min_next = (hu_head < acc_reg) ? hu_head : acc_reg;
    assign max_next = (cd_head > acc_reg) ? cd_head : acc_reg;

    assign up_sum  = {1'b0, smoothed_reg} + {1'b0, ramp_up_reg};
    assign up_cand = (up_sum > {1'b0, full_duty_reg}) ? full_duty_reg : up_sum[DUTY_W-1:0];
    assign dn_cand = (smoothed_reg < ramp_down_reg) ? '0 : smoothed_reg - ramp_down_reg;

    always_comb
    begin
        slew_next = duty_reg;
        if ((duty_reg < smoothed_reg) && (smoothed_reg > SMIN) && (dn_cand > duty_reg))
        begin
            slew_next = dn_cand;
        end
        if ((duty_reg > smoothed_reg) && (duty_reg > SMIN) && (up_cand < duty_reg))
        begin
            slew_next = up_cand;
        end
    end

    assign changed  = (duty_reg != current_reg);
    assign out_free = !out_valid_reg || !out_stall;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_duty_reg <= 8'd255;
            ramp_up_reg   <= 8'd5;
            ramp_down_reg <= 8'd2;
            pts_used_reg  <= '0;
            pts_lower_reg <= '0;
            pts_upper_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FULL_DUTY: full_duty_reg <= cfg_data[DUTY_W-1:0];
                REG_RAMP_UP:   ramp_up_reg   <= cfg_data[DUTY_W-1:0];
                REG_RAMP_DOWN: ramp_down_reg <= cfg_data[DUTY_W-1:0];
                REG_PTS_USED:  pts_used_reg  <= cfg_data[3:0];
                REG_PTS_LOWER: pts_lower_reg <= cfg_data;
                REG_PTS_UPPER: pts_upper_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, duty state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            temp_reg      <= '0;
            force_reg     <= 1'b0;
            idx_reg       <= '0;
            pt_reg        <= '0;
            pd_reg        <= '0;
            prod_reg      <= '0;
            dsr_reg       <= '0;
            duty_reg      <= '0;
            acc_reg       <= '0;
            rot_cnt_reg   <= '0;
            smoothed_reg  <= '0;
            current_reg   <= '0;
            out_valid_reg <= 1'b0;
            pwm_out_reg   <= '0;
            tgt_out_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        temp_reg  <= temp_in;
                        force_reg <= force_max;
                        idx_reg   <= '0;
                        pt_reg    <= '0;
                        pd_reg    <= '0;
                        if (!powered_on)
                        begin
                            duty_reg  <= '0;
                            state_reg <= ST_FINISH;
                        end
                        else if (force_max)
                        begin
                            duty_reg  <= full_duty_reg;
                            state_reg <= ST_FINISH;
                        end
                        else
                        begin
                            state_reg <= ST_CURVE;
                        end
                    end
                end

                ST_CURVE:
                begin
                    if (idx_reg >= n_eff)
                    begin
                        duty_reg  <= full_duty_reg;
                        state_reg <= ST_HU_PUSH;
                    end
                    else if (temp_reg == ct)
                    begin
                        duty_reg  <= cd;
                        state_reg <= ST_HU_PUSH;
                    end
                    else if ((temp_reg < ct) && (idx_reg == '0))
                    begin
                        duty_reg  <= '0;
                        state_reg <= ST_HU_PUSH;
                    end
                    else if ((temp_reg < ct) && (temp_reg > pt_reg))
                    begin
                        prod_reg  <= prod_next;
                        dsr_reg   <= dden[7:0];
                        state_reg <= ST_MUL;
                    end
                    else
                    begin
                        pt_reg  <= ct;
                        pd_reg  <= cd;
                        idx_reg <= idx_reg + 4'd1;
                    end
                end

                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end

                ST_DIV:
                begin
                    if (div_done)
                    begin
                        duty_reg  <= interp_duty;
                        state_reg <= ST_HU_PUSH;
                    end
                end

                ST_HU_PUSH:
                begin
                    acc_reg     <= duty_reg;
                    rot_cnt_reg <= ROT_W'(HEATUP_DEPTH - 1);
                    state_reg   <= ST_HU_ROT;
                end

                ST_HU_ROT:
                begin
                    acc_reg <= min_next;
                    if (rot_cnt_reg == '0)
                    begin
                        duty_reg  <= min_next;
                        state_reg <= ST_CD_PUSH;
                    end
                    else
                    begin
                        rot_cnt_reg <= rot_cnt_reg - ROT_W'(1);
                    end
                end

                ST_CD_PUSH:
                begin
                    acc_reg     <= duty_reg;
                    rot_cnt_reg <= ROT_W'(COOLDOWN_DEPTH - 1);
                    state_reg   <= ST_CD_ROT;
                end

                ST_CD_ROT:
                begin
                    acc_reg <= max_next;
                    if (rot_cnt_reg == '0)
                    begin
                        duty_reg  <= max_next;
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        rot_cnt_reg <= rot_cnt_reg - ROT_W'(1);
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        if (changed)
                        begin
                            smoothed_reg <= slew_next;
                            current_reg  <= force_reg ? full_duty_reg : slew_next;
                            pwm_out_reg  <= force_reg ? full_duty_reg : slew_next;
                            tgt_out_reg  <= slew_next;
                        end
                        else
                        begin
                            pwm_out_reg <= current_reg;
                            tgt_out_reg <= duty_reg;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign fan_duty    = pwm_out_reg;
    assign target_duty = tgt_out_reg;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != ST_IDLE))
        else $error("accepted item did not start processing");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV))
        else $error("divider finished outside interpolation");

    a_hu_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HU_ROT) |-> (rot_cnt_reg <= ROT_W'(HEATUP_DEPTH - 1)))
        else $error("heat-up rotation count out of range");

    a_duty_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_FINISH) |=> $stable(current_reg))
        else $error("current duty changed outside finish");

endmodule

>>> dv/fan_curve_duty_controller_tb.sv
`timescale 1ns / 1ps
// Testbench for fan_curve_duty_controller: a directed table, then randomized curves and ticks.
// Items are scored against a given result or an in-bench predictor. Needs fcd_pkg and the RTL.
module testbench;
    import fcd_pkg::*;

    localparam int HEAT_N      = DEF_HEATUP_DEPTH;
    localparam int COOL_N      = DEF_COOLDOWN_DEPTH;
    localparam int MAX_PTS     = DEF_MAX_POINTS;
    localparam int SMOOTH_MIN  = DEF_SMOOTH_MIN;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE      = 64;
    localparam int RAND_PHASES = 12;
    localparam int PHASE_TICKS = 80;

    // indexes past the register list
    localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;

    typedef struct packed {
        logic [DUTY_W-1:0] pwm;
        logic [DUTY_W-1:0] tgt;
    } duty_pair_t;

    typedef struct {
        logic                     is_cfg;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_W-1:0]         data;
        logic signed [TEMP_W-1:0] cpu;
        logic signed [TEMP_W-1:0] gpu;
        logic                     pw;
        logic                     fm;
        logic                     known;
        duty_pair_t               res;
    } script_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic signed [TEMP_W-1:0] cpu_temp = '0;
    logic signed [TEMP_W-1:0] gpu_temp = '0;
    logic                     powered_on = 1'b0;
    logic                     force_max = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [DUTY_W-1:0]        fan_duty;
    logic [DUTY_W-1:0]        target_duty;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_W-1:0]         cfg_data = '0;

    logic       exp_known = 1'b0;
    duty_pair_t exp_given = '0;
    bit         calm = 1'b0;

    // predictor copy of config and state
    int               cfg_full = 255;
    int               cfg_up = 5;
    int               cfg_down = 2;
    int               cfg_npts = 0;
    logic [CFG_W-1:0] cfg_lo = '0;
    logic [CFG_W-1:0] cfg_hi = '0;
    logic [7:0]       heat_win [HEAT_N] = '{default: '0};
    logic [7:0]       cool_win [COOL_N] = '{default: '0};
    int               smooth_q = 0;
    int               duty_q = 0;

    duty_pair_t  pending_duty [$];
    script_row_t script [$];
    int n_items = 0, n_checked = 0, n_errors = 0, n_writes = 0, n_forced = 0, n_off = 0;
    int cycles = 0;

    fan_curve_duty_controller dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cpu_temp    (cpu_temp),
        .gpu_temp    (gpu_temp),
        .powered_on  (powered_on),
        .force_max   (force_max),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fan_duty    (fan_duty),
        .target_duty (target_duty),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int curve_lookup(int t);
        int n, ct, cd, pt, pd, sh;
        logic [CFG_W-1:0] r;
        n = (cfg_npts > MAX_PTS) ? MAX_PTS : cfg_npts;
        pt = 0;
        pd = 0;
        for (int i = 0; i < n; i++)
        begin
            r = (i < 4) ? cfg_lo : cfg_hi;
            sh = 16 * (i % 4);
            ct = $signed(r[sh +: 8]);
            cd = r[sh + 8 +: 8];
            if (t == ct)
                return cd;
            if (t < ct)
            begin
                if (i == 0)
                    return 0;
                if (t > pt)
                    return (pd + ((t - pt) * (cd - pd)) / (ct - pt)) & 255;
            end
            pt = ct;
            pd = cd;
        end
        return cfg_full;
    endfunction

    function automatic int heat_min(int duty);
        int low;
        low = duty;
        for (int i = 0; i + 1 < HEAT_N; i++)
        begin
            if (heat_win[i + 1] < low)
                low = heat_win[i + 1];
            heat_win[i] = heat_win[i + 1];
        end
        heat_win[HEAT_N - 1] = duty[7:0];
        return low;
    endfunction

    function automatic int cool_max(int duty);
        int high;
        high = duty;
        for (int i = 0; i + 1 < COOL_N; i++)
        begin
            if (cool_win[i + 1] > high)
                high = cool_win[i + 1];
            cool_win[i] = cool_win[i + 1];
        end
        cool_win[COOL_N - 1] = duty[7:0];
        return high;
    endfunction

    function automatic int slew_limit(int last, int duty);
        int next, cand;
        next = duty;
        if (duty < last)
        begin
            cand = (last < cfg_down) ? 0 : last - cfg_down;
            if (last > SMOOTH_MIN && cand > duty)
                next = cand;
        end
        if (duty > last)
        begin
            cand = (last > cfg_full - cfg_up) ? cfg_full : last + cfg_up;
            if (duty > SMOOTH_MIN && cand < duty)
                next = cand;
        end
        return next & 255;
    endfunction

    function automatic void predict_duty(input logic signed [7:0] cpu, input logic signed [7:0] gpu,
                                         input logic pw, input logic fm, output duty_pair_t res);
        int t, tgt;
        t = cpu;
        if (DEF_HAS_GPU != 0 && gpu > cpu)
            t = gpu;
        if (pw)
        begin
            tgt = curve_lookup(t);
            if (fm)
                tgt = cfg_full;
            else
                tgt = cool_max(heat_min(tgt));
        end
        else
            tgt = 0;
        if (tgt != duty_q)
        begin
            tgt = slew_limit(smooth_q, tgt);
            smooth_q = tgt;
            duty_q = fm ? cfg_full : tgt;
        end
        res.pwm = duty_q[7:0];
        res.tgt = tgt[7:0];
    endfunction

    function automatic script_row_t cfg_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        script_row_t r;
        r = '{is_cfg: 1'b1, idx: idx, data: data, cpu: '0, gpu: '0, pw: 1'b0, fm: 1'b0,
              known: 1'b0, res: '0};
        return r;
    endfunction

    function automatic script_row_t tick_step(int cpu, int gpu, bit pw, bit fm,
                                              bit known = 0, int pwm = 0, int tgt = 0);
        script_row_t r;
        r = '{is_cfg: 1'b0, idx: REG_FULL_DUTY, data: '0, cpu: cpu[7:0], gpu: gpu[7:0], pw: pw,
              fm: fm, known: known, res: '{pwm: pwm[7:0], tgt: tgt[7:0]}};
        return r;
    endfunction

    function automatic logic [15:0] curve_pt(int t, int d);
        return {d[7:0], t[7:0]};
    endfunction

    function automatic logic [7:0] pick_temp();
        int v;
        if ($urandom_range(0, 4) == 0)
            return 8'($urandom_range(0, 255));
        v = $urandom_range(0, 150);
        v = v - 40;
        return v[7:0];
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_FULL_DUTY: cfg_full = data[7:0];
            REG_RAMP_UP:   cfg_up   = data[7:0];
            REG_RAMP_DOWN: cfg_down = data[7:0];
            REG_PTS_USED:  cfg_npts = data[3:0];
            REG_PTS_LOWER: cfg_lo   = data;
            REG_PTS_UPPER: cfg_hi   = data;
            default: ;
        endcase
        n_writes++;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_duty.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_item(logic [7:0] cpu, logic [7:0] gpu, logic pw, logic fm,
                             logic known, duty_pair_t res);
        if (!calm && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 90)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cpu_temp   <= cpu;
        gpu_temp   <= gpu;
        powered_on <= pw;
        force_max  <= fm;
        exp_known  <= known;
        exp_given  <= res;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
    endtask

    task automatic load_phase_config(int phase);
        logic [15:0] pts [8];
        int t, d, full, up, down;
        if (phase == 0)
        begin
            full = 255; up = 0; down = 0;
        end
        else if (phase == 1)
        begin
            full = 1; up = 255; down = 255;
        end
        else
        begin
            full = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(1, 255);
            up   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 40);
            down = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 40);
        end
        write_reg(REG_FULL_DUTY, {$urandom, 24'($urandom_range(0, 'hFFFFFF)), full[7:0]});
        write_reg(REG_RAMP_UP,   {$urandom, 24'($urandom_range(0, 'hFFFFFF)), up[7:0]});
        write_reg(REG_RAMP_DOWN, {$urandom, 24'($urandom_range(0, 'hFFFFFF)), down[7:0]});
        write_reg(REG_PTS_USED, {$urandom, 28'($urandom),
                  4'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(2, 8))});
        if ($urandom_range(0, 4) == 0)
        begin
            write_reg(REG_PTS_LOWER, {$urandom, $urandom});
            write_reg(REG_PTS_UPPER, {$urandom, $urandom});
        end
        else
        begin
            t = $urandom_range(0, 80);
            t = t - 50;
            d = $urandom_range(0, 60);
            for (int p = 0; p < 8; p++)
            begin
                pts[p] = curve_pt(t, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : d);
                t = t + $urandom_range(1, 30);
                if (t > 127)
                    t = 127;
                d = d + $urandom_range(0, 60);
                if (d > 255)
                    d = 255;
            end
            write_reg(REG_PTS_LOWER, {pts[3], pts[2], pts[1], pts[0]});
            write_reg(REG_PTS_UPPER, {pts[7], pts[6], pts[5], pts[4]});
        end
        if ($urandom_range(0, 2) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, {$urandom, $urandom});
    endtask

    always @(posedge clk)
    begin
        out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 30);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results outstanding",
                     $realtime, cycles, pending_duty.size());
            $display("fan_curve_duty_controller test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin : scoreboard
        duty_pair_t want, got;
        if (rst_n)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                got = '{pwm: fan_duty, tgt: target_duty};
                if (pending_duty.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: unexpected result fan_duty=%0d target_duty=%0d",
                             $realtime, got.pwm, got.tgt);
                end
                else
                begin
                    want = pending_duty.pop_front();
                    n_checked++;
                    if (got.pwm !== want.pwm)
                    begin
                        n_errors++;
                        $display("%0t: fan_duty expected %0d got %0d",
                                 $realtime, want.pwm, got.pwm);
                    end
                    if (got.tgt !== want.tgt)
                    begin
                        n_errors++;
                        $display("%0t: target_duty expected %0d got %0d",
                                 $realtime, want.tgt, got.tgt);
                    end
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
            begin
                predict_duty(cpu_temp, gpu_temp, powered_on, force_max, want);
                pending_duty.push_back(exp_known ? exp_given : want);
                n_items++;
                if (force_max)
                    n_forced++;
                if (!powered_on)
                    n_off++;
            end
        end
    end

    initial
    begin
        // reset defaults: empty curve, so any powered tick looks up full duty on the curve
        script.push_back(tick_step(0, 0, 0, 0, 1, 0, 0));
        script.push_back(tick_step(-128, 127, 1, 1, 1, 255, 5));
        script.push_back(tick_step(127, -128, 1, 1, 1, 255, 255));
        script.push_back(tick_step(-128, -128, 0, 0));
        script.push_back(tick_step(127, 127, 1, 0));
        script.push_back(tick_step(-1, -2, 0, 1));
        // upper bits of narrow registers are dropped; ramps wide enough to overflow
        script.push_back(cfg_step(REG_FULL_DUTY, 64'hA5A5_A5A5_A5A5_A5C8));
        script.push_back(cfg_step(REG_RAMP_UP, 64'hFF));
        script.push_back(cfg_step(REG_RAMP_DOWN, 64'hFFFF_FFFF_FFFF_FFFF));
        script.push_back(cfg_step(REG_PTS_USED, 64'h4));
        script.push_back(cfg_step(REG_PTS_LOWER, {curve_pt(90, 250), curve_pt(61, 40),
                                                  curve_pt(30, 100), curve_pt(-20, 0)}));
        script.push_back(cfg_step(REG_PTS_UPPER, {curve_pt(127, 30), curve_pt(110, 20),
                                                  curve_pt(50, 10), curve_pt(100, 255)}));
        script.push_back(tick_step(-128, -128, 1, 0));
        script.push_back(tick_step(-20, -90, 1, 0));
        script.push_back(tick_step(10, 31, 1, 0));
        script.push_back(tick_step(45, 0, 1, 0));
        script.push_back(tick_step(127, 5, 1, 0));
        script.push_back(tick_step(75, 75, 1, 0));
        // point count beyond the curve size, upper half deliberately out of order
        script.push_back(cfg_step(REG_PTS_USED, 64'hF));
        script.push_back(tick_step(105, 105, 1, 0));
        script.push_back(tick_step(127, 127, 1, 0));
        script.push_back(tick_step(55, -3, 1, 0));
        script.push_back(cfg_step(REG_SPARE6, 64'hFFFF_FFFF_FFFF_FFFF));
        script.push_back(cfg_step(REG_SPARE7, 64'h5));
        script.push_back(cfg_step(REG_FULL_DUTY, 64'hFFFF_FFFF_FFFF_FF01));
        script.push_back(tick_step(0, 0, 1, 1));
        script.push_back(tick_step(0, 0, 1, 0));

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_cfg)
            begin
                drain_results();
                write_reg(script[i].idx, script[i].data);
            end
            else
                send_item(script[i].cpu, script[i].gpu, script[i].pw, script[i].fm,
                          script[i].known, script[i].res);
        end

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            drain_results();
            calm = (ph == 5 || ph == 6);
            load_phase_config(ph);
            for (int k = 0; k < PHASE_TICKS; k++)
                send_item(pick_temp(), pick_temp(), $urandom_range(0, 99) < 90,
                          $urandom_range(0, 99) < 8, 1'b0, '0);
        end

        drain_results();
        $display("ran %0d ticks (%0d forced, %0d unpowered), %0d results scored",
                 n_items, n_forced, n_off, n_checked);
        $display("across %0d register writes and %0d random curve settings", n_writes,
                 RAND_PHASES);
        if (n_errors == 0)
            $display("fan_curve_duty_controller test passed");
        else
            $display("fan_curve_duty_controller test failed");
        $finish;
    end

endmodule
